/* rtl/core/conv2d_5x5_clamped_edges_defines.svh */
// Assertion helpers shared by the convolution RTL.
`ifndef CONV2D_5X5_CLAMPED_EDGES_DEFINES_SVH
`define CONV2D_5X5_CLAMPED_EDGES_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define C2D_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define C2D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/c2d_pkg.sv */
package c2d_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned KERNEL_SIZE   = 5;
  localparam int unsigned HALF_K        = KERNEL_SIZE / 2;
  localparam int unsigned ROW_SLOTS     = 3 * HALF_K + 2;
  localparam int unsigned SLOT_W        = $clog2(ROW_SLOTS);
  localparam int unsigned PIXEL_BITS    = 16;
  localparam int unsigned COEF_W        = 12;
  localparam int unsigned COEF_ROW_W    = KERNEL_SIZE * COEF_W;
  localparam int unsigned PROD_W        = PIXEL_BITS + COEF_W;
  localparam int unsigned ROWSUM_W      = PROD_W + 3;
  localparam int unsigned SUM_W         = ROWSUM_W + 3;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned ROW_W         = 16;
  localparam int unsigned OCOL_W        = 10;
  localparam int unsigned WREG_W        = 11;
  localparam int unsigned OUT_TDATA_W   = 64;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 6;
  localparam int unsigned REG_IDX_W     = 3;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(1024);

  // Register indexes; byte address is eight times the index.
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_ROW0    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_ROW1    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_ROW2    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_ROW3    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COEF_ROW4    = 3'd6;

  // Input kind carried on tuser.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

endpackage

/* rtl/core/conv2d_5x5_clamped_edges.sv */
`include "conv2d_5x5_clamped_edges_defines.svh"
// 5x5 streaming convolution with replicated borders.
// Pixels enter in raster order on the slave stream, one beat per clock while
// tready is high (tuser low); after the last pixel of a frame the source sends
// drain beats (tuser high) to push out the outputs still owed. Each output beat
// carries the sum, its row and column, and tlast on the bottom-right pixel of
// the frame. An output (r,c) is produced by the input beat of pixel (r+2,c+2)
// in raster order, so the stream trails the input by two rows and two pixels.
// Stages: input register, 25 products, five row sums, then the output register.
// A new beat is taken every cycle unless the receiver stalls, set by the single
// memory read of one column per beat. Eight row slots of line memory hold one
// column word per read address. The user must write kernel and frame size over
// the APB port only while the stream is idle; the block itself does not enforce
// it. Reset clears counters and valid flags; the line memory is not cleared and
// its contents are undefined until written. When the receiver stalls, the whole
// pipeline holds and tready drops in the same cycle, so no beat is lost.
module conv2d_5x5_clamped_edges #(
  parameter int unsigned MAX_WIDTH = c2d_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: pixel[15:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [c2d_pkg::PIXEL_BITS-1:0]     s_tdata,
  // tuser: kind[0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata: value[31:0], out_row[47:32], out_column[57:48], zeros above
  output logic [c2d_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [c2d_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [c2d_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import c2d_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = CW + 2;
  localparam int unsigned PW = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned RW = ROW_W + 2;

  // Configuration registers.
  logic [WREG_W-1:0]     width_q;
  logic [ROW_W-1:0]      height_q;
  logic [COEF_ROW_W-1:0] coef_q [KERNEL_SIZE];
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      for (int i = 0; i < KERNEL_SIZE; i++) coef_q[i] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_q   <= pwdata[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_q  <= pwdata[ROW_W-1:0];
        REG_COEF_ROW0:    coef_q[0] <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW1:    coef_q[1] <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW2:    coef_q[2] <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW3:    coef_q[3] <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW4:    coef_q[4] <= pwdata[COEF_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_q);
      REG_COEF_ROW0:    prdata = CFG_DATA_W'(coef_q[0]);
      REG_COEF_ROW1:    prdata = CFG_DATA_W'(coef_q[1]);
      REG_COEF_ROW2:    prdata = CFG_DATA_W'(coef_q[2]);
      REG_COEF_ROW3:    prdata = CFG_DATA_W'(coef_q[3]);
      REG_COEF_ROW4:    prdata = CFG_DATA_W'(coef_q[4]);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero means one, width saturates at the line length.
  logic [WW-1:0]    w_eff;
  logic [CW-1:0]    wm1;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] hm1;
  logic [PW-1:0]    lag;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    wm1   = CW'(w_eff - WW'(1));
    h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
    hm1   = h_eff - ROW_W'(1);
    lag   = PW'(HALF_K * w_eff + HALF_K);
  end

  // Pipeline control: one global enable, the output register parts the sides.
  logic en;
  logic v0_q, v1_q, v2_q, vo_q;
  logic kind0_q;
  logic [PIXEL_BITS-1:0] pix0_q;

  assign en       = !vo_q || m_tready;
  assign s_tready = en;
  assign m_tvalid = vo_q;

  // Position counters and the count of pixels still owed an output.
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [CW-1:0]    in_col_q, out_col_q;
  logic [PW-1:0]    pend_q;
  logic             proc, is_pix, emit;
  logic             in_col_end, in_row_end, out_col_end, out_row_end;

  assign proc   = en && v0_q;
  assign is_pix = (kind0_q == KIND_PIXEL);

  always_comb begin
    in_col_end  = (WW'(in_col_q) + WW'(1)) >= w_eff;
    in_row_end  = (17'(in_row_q) + 17'd1) >= 17'(h_eff);
    out_col_end = (WW'(out_col_q) + WW'(1)) >= w_eff;
    out_row_end = (17'(out_row_q) + 17'd1) >= 17'(h_eff);
    if (!proc) begin
      emit = 1'b0;
    end else if (is_pix) begin
      emit = (PW'(pend_q + PW'(1)) > lag);
    end else begin
      emit = (in_row_q == '0) && (in_col_q == '0) && (pend_q != '0);
    end
  end

  // Line memory write: one row slot per pixel.
  logic                  we;
  logic [SLOT_W-1:0]     wslot;
  logic [CW-1:0]         wa;
  logic [CW-1:0]         ra;

  assign we    = proc && is_pix;
  assign wslot = in_row_q[SLOT_W-1:0];
  assign wa    = (32'(in_col_q) < MAX_WIDTH) ? in_col_q : CW'(MAX_WIDTH - 1);

  // Column window: entry k holds the column clamp(c-2+k) for all row slots.
  // The prefetch register holds clamp(c+3); the first-column copies hold
  // columns 0..2 so that a row start can load its window in one step.
  logic [PIXEL_BITS-1:0] win_q  [KERNEL_SIZE][ROW_SLOTS];
  logic [PIXEL_BITS-1:0] win_fw [KERNEL_SIZE][ROW_SLOTS];
  logic [PIXEL_BITS-1:0] win_d  [KERNEL_SIZE][ROW_SLOTS];
  logic [PIXEL_BITS-1:0] pre_q  [ROW_SLOTS];
  logic [PIXEL_BITS-1:0] pfw    [ROW_SLOTS];
  logic [PIXEL_BITS-1:0] fst_q  [3][ROW_SLOTS];
  logic [PIXEL_BITS-1:0] ffw    [3][ROW_SLOTS];
  logic [PIXEL_BITS-1:0] rd_q   [ROW_SLOTS];
  logic                  rd_pend_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     hit_slot_q;
  logic [PIXEL_BITS-1:0] hit_px_q;

  logic [CW-1:0]         ctag  [KERNEL_SIZE + 1];
  logic [CW-1:0]         ntag0 [KERNEL_SIZE];
  logic [CW-1:0]         ncol;
  logic signed [SW-1:0]  cv    [KERNEL_SIZE + 1];
  logic signed [SW-1:0]  nv0   [KERNEL_SIZE];
  logic signed [SW-1:0]  rv;
  logic signed [SW-1:0]  wm1_s;

  always_comb begin
    wm1_s = signed'({2'b00, wm1});
    for (int k = 0; k <= KERNEL_SIZE; k++) begin
      cv[k] = signed'({2'b00, out_col_q}) + SW'(k - HALF_K);
      if (cv[k] < 0) begin
        ctag[k] = '0;
      end else if (cv[k] > wm1_s) begin
        ctag[k] = wm1;
      end else begin
        ctag[k] = cv[k][CW-1:0];
      end
    end
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      nv0[k] = SW'(k - HALF_K);
      if (nv0[k] < 0) begin
        ntag0[k] = '0;
      end else if (nv0[k] > wm1_s) begin
        ntag0[k] = wm1;
      end else begin
        ntag0[k] = nv0[k][CW-1:0];
      end
    end
    ncol = out_col_end ? '0 : CW'(out_col_q + CW'(1));
    rv   = signed'({2'b00, ncol}) + SW'(HALF_K + 1);
    if (rv > wm1_s) begin
      ra = wm1;
    end else begin
      ra = rv[CW-1:0];
    end
  end

  // Forward this cycle's memory write into every copy that shows its column.
  always_comb begin
    for (int s = 0; s < ROW_SLOTS; s++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        win_fw[k][s] = (we && wa == ctag[k] && wslot == SLOT_W'(s)) ? pix0_q : win_q[k][s];
      end
      if (rd_pend_q) begin
        pfw[s] = (hit_q && hit_slot_q == SLOT_W'(s)) ? hit_px_q : rd_q[s];
      end else begin
        pfw[s] = pre_q[s];
      end
      if (we && wa == ctag[KERNEL_SIZE] && wslot == SLOT_W'(s)) pfw[s] = pix0_q;
      for (int f = 0; f < 3; f++) begin
        ffw[f][s] = (we && wa == CW'(f) && wslot == SLOT_W'(s)) ? pix0_q : fst_q[f][s];
      end
    end
  end

  // Next window: shift in the prefetched column, or reload at a row start.
  always_comb begin
    for (int s = 0; s < ROW_SLOTS; s++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        if (!emit) begin
          win_d[k][s] = win_fw[k][s];
        end else if (out_col_end) begin
          win_d[k][s] = ffw[ntag0[k][1:0]][s];
        end else if (k == KERNEL_SIZE - 1) begin
          win_d[k][s] = pfw[s];
        end else begin
          win_d[k][s] = win_fw[k+1][s];
        end
      end
    end
  end

  for (genvar s = 0; s < ROW_SLOTS; s++) begin : g_bank
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (we && wslot == SLOT_W'(s)) mem[wa] <= pix0_q;
      if (emit) rd_q[s] <= mem[ra];
    end
  end

  // Row slots of the five kernel rows, clamped to the frame.
  logic [SLOT_W-1:0]    rslot [KERNEL_SIZE];
  logic signed [RW-1:0] rrow  [KERNEL_SIZE];

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rrow[i] = signed'({2'b00, out_row_q}) + RW'(HALF_K - i);
      if (rrow[i] < 0) begin
        rslot[i] = '0;
      end else if (rrow[i] > signed'({2'b00, hm1})) begin
        rslot[i] = hm1[SLOT_W-1:0];
      end else begin
        rslot[i] = rrow[i][SLOT_W-1:0];
      end
    end
  end

  // Kernel row i meets image row r+2-i, kernel column j meets column c+2-j.
  logic signed [PROD_W-1:0]   prod_d [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PROD_W-1:0]   prod_q [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [ROWSUM_W-1:0] rsum_d [KERNEL_SIZE];
  logic signed [ROWSUM_W-1:0] rsum_q [KERNEL_SIZE];
  logic signed [SUM_W-1:0]    sum_d;

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        prod_d[i][j] = $signed(coef_q[i][COEF_W*j +: COEF_W])
                     * $signed(win_fw[KERNEL_SIZE-1-j][rslot[i]]);
      end
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rsum_d[i] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        rsum_d[i] = rsum_d[i] + ROWSUM_W'(prod_q[i][j]);
      end
    end
    sum_d = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      sum_d = sum_d + SUM_W'(rsum_q[i]);
    end
  end

  // Position and end-of-frame flag travel with the sums.
  logic [ROW_W-1:0]  row1_q, row2_q;
  logic [OCOL_W-1:0] col1_q, col2_q;
  logic              last1_q, last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      vo_q      <= 1'b0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pend_q    <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (en) begin
      v0_q      <= s_tvalid;
      v1_q      <= emit;
      v2_q      <= v1_q;
      vo_q      <= v2_q;
      rd_pend_q <= emit;
      hit_q     <= emit && we && (wa == ra);
      if (we) begin
        if (in_col_end) begin
          in_col_q <= '0;
          in_row_q <= in_row_end ? '0 : in_row_q + ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_q <= '0;
          out_row_q <= out_row_end ? '0 : out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
      if (proc && is_pix && !emit) begin
        pend_q <= pend_q + PW'(1);
      end else if (proc && !is_pix && emit) begin
        pend_q <= pend_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_tvalid) begin
        kind0_q <= s_tuser;
        pix0_q  <= s_tdata;
      end
      for (int s = 0; s < ROW_SLOTS; s++) begin
        for (int k = 0; k < KERNEL_SIZE; k++) win_q[k][s] <= win_d[k][s];
        for (int f = 0; f < 3; f++) fst_q[f][s] <= ffw[f][s];
        pre_q[s] <= pfw[s];
      end
      hit_slot_q <= wslot;
      hit_px_q   <= pix0_q;
      prod_q     <= prod_d;
      rsum_q     <= rsum_d;
      row1_q     <= out_row_q;
      col1_q     <= OCOL_W'(out_col_q);
      last1_q    <= (out_row_q == hm1) && (out_col_q == wm1);
      row2_q     <= row1_q;
      col2_q     <= col1_q;
      last2_q    <= last1_q;
      m_tdata    <= OUT_TDATA_W'({col2_q, row2_q, sum_d[VALUE_W-1:0]});
      m_tlast    <= last2_q;
    end
  end

  `C2D_ASSERT_NOW(a_hit_has_read, hit_q, rd_pend_q, "write forward recorded without a read")
  `C2D_ASSERT_NEXT(a_emit_enters_pipe, emit, v1_q, "emitted output did not enter the pipe")
  `C2D_ASSERT_NEXT(a_pipe_reaches_out, v2_q && en, m_tvalid, "row sums lost before output")

endmodule

/* sim/tb.sv */
module tb;
  import c2d_pkg::*;

  // One output beat as the block should produce it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
    logic [OCOL_W-1:0]         column;
    logic                      last;
  } conv_beat_t;

  // One input beat: the kind on tuser and the pixel on tdata.
  typedef struct packed {
    logic                         kind;
    logic signed [PIXEL_BITS-1:0] pixel;
  } in_beat_t;

  localparam int unsigned STORE_W = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIXEL_BITS-1:0] s_tdata = '0;
  logic s_tuser = KIND_PIXEL;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  conv2d_5x5_clamped_edges dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers and state, kept by the predictor.
  logic [WREG_W-1:0]     width_reg = WIDTH_RESET;
  logic [ROW_W-1:0]      height_reg = HEIGHT_RESET;
  logic [COEF_ROW_W-1:0] coef_reg [KERNEL_SIZE];
  int line_mem [ROW_SLOTS][STORE_W];
  int in_row, in_col, out_row, out_col, pending;

  in_beat_t   beat_q[$];       // beats waiting to be offered to the block
  conv_beat_t conv_expect_q[$]; // predicted outputs not yet seen
  int errors = 0;
  int beats_taken = 0;
  int outputs_seen = 0;
  int frames_done = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit took_beat = 1'b0;

  function automatic int frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > STORE_W) return STORE_W;
    return width_reg;
  endfunction

  function automatic int frame_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Raster advance with wrap at the current frame bounds.
  function automatic void step_pos(inout int row, inout int col, input int w, input int h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : ((row + 1) & 16'hFFFF);
    end else begin
      col = col + 1;
    end
  endfunction

  // Convolve at the next output position with the kernel flipped and the
  // border replicated, then advance the output position.
  function automatic conv_beat_t convolve_next(input int w, input int h);
    conv_beat_t res;
    longint acc;
    int rr, cc;
    logic signed [COEF_W-1:0] k;
    acc = 0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        rr = out_row - (i - HALF_K);
        cc = out_col - (j - HALF_K);
        if (rr < 0) rr = 0;
        if (rr > h - 1) rr = h - 1;
        if (cc < 0) cc = 0;
        if (cc > w - 1) cc = w - 1;
        k = coef_reg[i][COEF_W*j +: COEF_W];
        acc += longint'(line_mem[rr % ROW_SLOTS][cc]) * longint'(k);
      end
    end
    res.value = acc[31:0];
    res.row = out_row[ROW_W-1:0];
    res.column = out_col[OCOL_W-1:0];
    res.last = (out_row == h - 1) && (out_col == w - 1);
    step_pos(out_row, out_col, w, h);
    pending--;
    return res;
  endfunction

  // Apply one accepted input beat; queue the output it releases, if any.
  function automatic void predict_beat(input in_beat_t b);
    int w, h;
    w = frame_width();
    h = frame_height();
    if (b.kind == KIND_PIXEL) begin
      line_mem[in_row % ROW_SLOTS][(in_col < STORE_W) ? in_col : STORE_W - 1] = int'(b.pixel);
      step_pos(in_row, in_col, w, h);
      pending++;
      if (pending > HALF_K * w + HALF_K) conv_expect_q.push_back(convolve_next(w, h));
    end else if (in_row == 0 && in_col == 0 && pending > 0) begin
      conv_expect_q.push_back(convolve_next(w, h));
    end
  endfunction

  // Input side: predict on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      predict_beat(beat_q.pop_front());
      beats_taken <= beats_taken + 1;
      took_beat <= 1'b1;
    end else begin
      took_beat <= 1'b0;
    end
  end

  // Driver: a beat that is offered stays put until the block takes it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && !took_beat) begin
        s_tvalid <= 1'b1;
      end else if (beat_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= beat_q[0].kind;
        s_tdata <= beat_q[0].pixel;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver hold-off, counted down here so the block backs up into its input.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      m_tready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: every output beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    conv_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      outputs_seen <= outputs_seen + 1;
      if (conv_expect_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected output beat: data=%h last=%b", m_tdata, m_tlast);
      end else begin
        want = conv_expect_q.pop_front();
        if (m_tdata !== {6'b0, want.column, want.row, want.value} || m_tlast !== want.last) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: want value=%0d row=%0d col=%0d last=%b, got value=%0d row=%0d col=%0d last=%b pad=%h",
                     want.value, want.row, want.column, want.last,
                     $signed(m_tdata[31:0]), m_tdata[47:32], m_tdata[57:48], m_tlast,
                     m_tdata[63:58]);
        end
      end
    end
  end

  // Register write with a setup phase and an access phase; the shadow copy follows it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = data[WREG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = data[ROW_W-1:0];
      default:          coef_reg[idx - REG_COEF_ROW0] = data[COEF_ROW_W-1:0];
    endcase
  endtask

  // Kernel style 0 is random, 1 is all most negative, 2 is all most positive.
  task automatic load_kernel(input int style);
    logic [COEF_ROW_W-1:0] row_bits;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++)
        row_bits[COEF_W*j +: COEF_W] = (style == 1) ? 12'h800 :
                                       (style == 2) ? 12'h7FF : COEF_W'($urandom);
      write_reg(REG_COEF_ROW0 + i, {4'b0, row_bits});
    end
  endtask

  function automatic logic [PIXEL_BITS-1:0] any_pixel();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // Queue a whole frame and enough drain beats to release what it still owes.
  task automatic queue_frame(input int extra_drains);
    int w, h, owed;
    w = frame_width();
    h = frame_height();
    for (int n = 0; n < w * h; n++) beat_q.push_back('{KIND_PIXEL, any_pixel()});
    owed = (w * h < HALF_K * w + HALF_K) ? w * h : HALF_K * w + HALF_K;
    for (int n = 0; n < owed + extra_drains; n++)
      beat_q.push_back('{KIND_DRAIN, PIXEL_BITS'($urandom)});
  endtask

  // The sender stops here until every expected beat is back and the pipe is empty.
  task automatic wait_quiet();
    wait (beat_q.size() == 0 && conv_expect_q.size() == 0);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < KERNEL_SIZE; i++) coef_reg[i] = '0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0; pending = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a 3x3 frame with extreme pixels and an extreme kernel, a drain
    // beat in the middle of the frame, and a drain beat when nothing is owed.
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    load_kernel(1);
    beat_q.push_back('{KIND_DRAIN, 16'h0000});
    beat_q.push_back('{KIND_PIXEL, 16'h8000});
    beat_q.push_back('{KIND_PIXEL, 16'h7FFF});
    beat_q.push_back('{KIND_DRAIN, 16'hFFFF});
    beat_q.push_back('{KIND_PIXEL, 16'h0000});
    beat_q.push_back('{KIND_PIXEL, 16'hFFFF});
    beat_q.push_back('{KIND_PIXEL, 16'h8000});
    beat_q.push_back('{KIND_PIXEL, 16'h7FFF});
    beat_q.push_back('{KIND_PIXEL, 16'h8000});
    beat_q.push_back('{KIND_PIXEL, 16'h5555});
    beat_q.push_back('{KIND_PIXEL, 16'hAAAA});
    for (int n = 0; n < 9; n++) beat_q.push_back('{KIND_DRAIN, 16'h0000});
    wait_quiet();
    load_kernel(2);
    write_reg(REG_IMAGE_HEIGHT, 0);
    queue_frame(2);
    wait_quiet();

    // Largest width on one row: every output comes out through drain beats.
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 1);
    load_kernel(0);
    queue_frame(0);
    wait_quiet();

    // Random frames, mostly small, through three idling regimes.
    while (beats_taken < 1050 + 1030) begin
      if (beats_taken < 1050 + 1030 / 3) begin
        tx_idle_pct = 37; rx_idle_pct = 61;
      end else if (beats_taken < 1050 + 2 * 1030 / 3) begin
        tx_idle_pct = 61; rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      write_reg(REG_IMAGE_WIDTH, $urandom_range(12));
      write_reg(REG_IMAGE_HEIGHT, $urandom_range(9));
      if ($urandom_range(3) == 0) load_kernel($urandom_range(2));
      else write_reg(REG_COEF_ROW0 + $urandom_range(4), {$urandom, $urandom});
      queue_frame($urandom_range(2));
      if (frames_done % 9 == 4) hold_req++;
      frames_done++;
      wait_quiet();
    end

    $display("Ran %0d input beats over %0d random frames plus directed ones, checked %0d outputs.",
             beats_taken, frames_done, outputs_seen);
    $display("Covered extreme pixels and kernels, widths 1 to 1024, drains and a long receiver stall.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats pending", beat_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
